FILE: sv/mchw_pkg.sv
// ----------------------------------------------------------------------------
// mchw_pkg: shared types and constants of the heartbeat watchdog
// Item layouts, operation and event codes, configuration indexes and the
// command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package mchw_pkg;

  // Operation carried by an input item.
  typedef enum logic [1:0] {
    MODE_TICK       = 2'd0,
    MODE_REGISTER   = 2'd1,
    MODE_DEREGISTER = 2'd2,
    MODE_HEARTBEAT  = 2'd3
  } mode_e;

  // Kind of a result item. Code 3 is never produced.
  typedef enum logic [1:0] {
    KIND_RESTART = 2'd0,
    KIND_REBOOT  = 2'd1,
    KIND_KICK    = 2'd2
  } kind_e;

  // Configuration register indexes.
  localparam logic CFG_DEFAULT_TIMEOUT = 1'b0;
  localparam logic CFG_DEFAULT_RETRIES = 1'b1;

  localparam int unsigned CfgDataW = 16;

  // Reset value of both default registers.
  localparam logic [CfgDataW-1:0] DEFAULT_RESET = 16'd100;

  typedef struct packed {
    mode_e       mode;
    logic [3:0]  slot;
    logic [15:0] timeout_value;
    logic        timeout_given;
    logic [15:0] retries_value;
    logic        retries_given;
  } in_item_t;

  typedef struct packed {
    kind_e      event_kind;
    logic [3:0] event_slot;
    logic       last_event;
  } out_item_t;

  // Controller to datapath.
  typedef struct packed {
    logic take;      // input item accepted this cycle
    logic hb_write;  // heartbeat reload write-back
    logic walk_adv;  // finish the current slot of a tick walk
    logic kick;      // load the closing kick event
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic step_ok;   // current walk slot can retire this cycle
    logic idx_last;  // walk is on the last slot
    logic out_free;  // output register can take an event
  } status_t;

endpackage

FILE: sv/mchw_ram.sv
// ----------------------------------------------------------------------------
// mchw_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module mchw_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/mchw_ctrl.sv
// ----------------------------------------------------------------------------
// mchw_ctrl: sequencing of the heartbeat watchdog
// Takes items while idle, runs the heartbeat write-back, the slot walk of a
// tick and the closing kick.
// ----------------------------------------------------------------------------
module mchw_ctrl import mchw_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  mode_e   in_mode_i,
  input  status_t status_i,
  output cmd_t    cmd_o,
  output logic    in_stall_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_HB   = 2'd1;
  localparam logic [1:0] ST_WALK = 2'd2;
  localparam logic [1:0] ST_KICK = 2'd3;

  logic [1:0] state_q;
  logic [1:0] state_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          if (in_mode_i == MODE_TICK) begin
            state_d = ST_WALK;
          end else if (in_mode_i == MODE_HEARTBEAT) begin
            state_d = ST_HB;
          end
        end
      end
      ST_HB: begin
        cmd_o.hb_write = 1'b1;
        state_d        = ST_IDLE;
      end
      ST_WALK: begin
        if (status_i.step_ok) begin
          cmd_o.walk_adv = 1'b1;
          if (status_i.idx_last) begin
            state_d = ST_KICK;
          end
        end
      end
      ST_KICK: begin
        if (status_i.out_free) begin
          cmd_o.kick = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);

endmodule

FILE: sv/mchw_dp.sv
// ----------------------------------------------------------------------------
// mchw_dp: slot table and event datapath of the heartbeat watchdog
// Holds the valid bits, the slot RAM, the default registers, the walk
// index and the output register.
// ----------------------------------------------------------------------------
module mchw_dp import mchw_pkg::*; #(
  parameter int unsigned SLOTS        = 16,
  parameter int unsigned COUNTER_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  in_item_t            in_data_i,
  input  cmd_t                cmd_i,
  output status_t             status_o,
  input  logic                out_stall_i,
  output logic                out_valid_o,
  output out_item_t           out_data_o
);

  localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CB    = COUNTER_BITS;
  localparam int unsigned RAM_W = 3 * CB;

  logic [CfgDataW-1:0] def_timeout_q;
  logic [CfgDataW-1:0] def_retries_q;
  logic [SLOTS-1:0]    valid_q;
  logic [SLOTS-1:0]    valid_d;
  logic [IDX_W-1:0]    idx_q;
  logic [IDX_W-1:0]    idx_d;
  logic [IDX_W-1:0]    hb_slot_q;
  logic                hb_ok_q;
  logic                out_valid_q;
  logic                out_valid_d;
  out_item_t           out_data_q;
  out_item_t           out_data_d;

  // Input slot mapped onto the table index.
  logic [IDX_W+3:0] in_slot_wide;
  logic [IDX_W-1:0] in_idx;
  logic             in_range;

  assign in_slot_wide = {{IDX_W{1'b0}}, in_data_i.slot};
  assign in_idx       = in_slot_wide[IDX_W-1:0];
  assign in_range     = (in_slot_wide < (IDX_W + 4)'(SLOTS));

  // Registration values, taken from the item or the defaults.
  logic [CfgDataW-1:0]    t_sel;
  logic [CfgDataW-1:0]    r_sel;
  logic [CB+CfgDataW-1:0] t_wide;
  logic [CB+CfgDataW-1:0] r_wide;
  logic [CB-1:0]          t_cnt;
  logic [CB-1:0]          r_cnt;

  assign t_sel  = in_data_i.timeout_given ? in_data_i.timeout_value : def_timeout_q;
  assign r_sel  = in_data_i.retries_given ? in_data_i.retries_value : def_retries_q;
  assign t_wide = {{CB{1'b0}}, t_sel};
  assign r_wide = {{CB{1'b0}}, r_sel};
  assign t_cnt  = t_wide[CB-1:0];
  assign r_cnt  = r_wide[CB-1:0];

  // Slot RAM: reload timeout, countdown, retries left.
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [RAM_W-1:0] ram_wdata;
  logic [IDX_W-1:0] ram_raddr;
  logic [RAM_W-1:0] ram_rdata;

  mchw_ram #(
    .WIDTH (RAM_W),
    .DEPTH (SLOTS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  logic [CB-1:0] rd_reload;
  logic [CB-1:0] rd_count;
  logic [CB-1:0] rd_retries;
  logic [CB-1:0] count_dec;
  logic [CB-1:0] retries_dec;
  logic          count_zero;
  logic          retries_zero;
  logic          cur_valid;
  logic          has_event;
  logic          out_free;

  assign rd_reload    = ram_rdata[RAM_W-1:2*CB];
  assign rd_count     = ram_rdata[2*CB-1:CB];
  assign rd_retries   = ram_rdata[CB-1:0];
  assign count_dec    = rd_count - CB'(1);
  assign retries_dec  = rd_retries - CB'(1);
  assign count_zero   = (rd_count == '0);
  assign retries_zero = (rd_retries == '0);
  assign cur_valid    = valid_q[idx_q];
  assign has_event    = cur_valid && count_zero;
  assign out_free     = !out_valid_q || !out_stall_i;

  assign status_o.step_ok  = !has_event || out_free;
  assign status_o.idx_last = (idx_q == IDX_W'(SLOTS - 1));
  assign status_o.out_free = out_free;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx_q;
    ram_wdata = {rd_reload, count_dec, rd_retries};
    priority if (cmd_i.take && (in_data_i.mode == MODE_REGISTER) && in_range
                 && !valid_q[in_idx]) begin
      ram_we    = 1'b1;
      ram_waddr = in_idx;
      ram_wdata = {t_cnt, t_cnt, r_cnt};
    end else if (cmd_i.hb_write && hb_ok_q && valid_q[hb_slot_q]) begin
      ram_we    = 1'b1;
      ram_waddr = hb_slot_q;
      ram_wdata = {rd_reload, rd_reload, rd_retries};
    end else if (cmd_i.walk_adv && cur_valid) begin
      ram_we    = 1'b1;
      ram_waddr = idx_q;
      ram_wdata = {rd_reload,
                   (count_zero && !retries_zero) ? rd_reload : count_dec,
                   count_zero ? retries_dec : rd_retries};
    end else begin
      ram_we = 1'b0;
    end
  end

  // Read: item slot on take (0 for tick), next slot on walk step, else held.
  always_comb begin
    priority if (cmd_i.take) begin
      ram_raddr = (in_data_i.mode == MODE_TICK) ? '0 : in_idx;
    end else if (cmd_i.walk_adv) begin
      ram_raddr = idx_q + IDX_W'(1);
    end else begin
      ram_raddr = idx_q;
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (cmd_i.take && in_range) begin
      if (in_data_i.mode == MODE_REGISTER) begin
        valid_d[in_idx] = 1'b1;
      end else if (in_data_i.mode == MODE_DEREGISTER) begin
        valid_d[in_idx] = 1'b0;
      end
    end
  end

  always_comb begin
    idx_d = idx_q;
    if (cmd_i.take) begin
      idx_d = '0;
    end else if (cmd_i.walk_adv) begin
      idx_d = idx_q + IDX_W'(1);
    end
  end

  // Output register.
  logic [IDX_W+3:0] idx_wide;

  assign idx_wide = {4'b0000, idx_q};

  always_comb begin
    out_data_d  = out_data_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (cmd_i.walk_adv && has_event) begin
      out_data_d.event_kind = retries_zero ? KIND_REBOOT : KIND_RESTART;
      out_data_d.event_slot = idx_wide[3:0];
      out_data_d.last_event = 1'b0;
      out_valid_d           = 1'b1;
    end else if (cmd_i.kick) begin
      out_data_d.event_kind = KIND_KICK;
      out_data_d.event_slot = 4'b0000;
      out_data_d.last_event = 1'b1;
      out_valid_d           = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      def_timeout_q <= DEFAULT_RESET;
      def_retries_q <= DEFAULT_RESET;
      valid_q       <= '0;
      idx_q         <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_DEFAULT_TIMEOUT) begin
          def_timeout_q <= cfg_data_i;
        end else begin
          def_retries_q <= cfg_data_i;
        end
      end
      valid_q     <= valid_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      hb_slot_q <= in_idx;
      hb_ok_q   <= in_range;
    end
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

FILE: sv/multi_channel_heartbeat_watchdog.sv
// ----------------------------------------------------------------------------
// multi_channel_heartbeat_watchdog: watchdog over a table of watched slots
// Register, deregister and heartbeat items maintain the slot table; a tick
// item counts every armed slot down and reports restart, reboot and kick
// events.
// ----------------------------------------------------------------------------
//
//   Channel   Direction   Handshake               Item
//   --------  ----------  ----------------------  -----------------------------
//   in        into block  in_valid_i / in_stall_o  in_data_i  (in_item_t)
//   out       out of blk  out_valid_o / out_stall_i out_data_o (out_item_t)
//   cfg       into block  cfg_we_i                 cfg_index_i, cfg_data_i
//
// A register or deregister item is done when it is accepted; a heartbeat
// item then writes the reload back to its slot. A tick item is accepted,
// walks the slot RAM, whose single read port reads one slot a cycle while
// the walk is not held, and ends with the closing kick; the walk holds while
// an event waits on a stalled output, and the kick waits on a stalled output.
// Reset clears the valid bits and sets both defaults to 100; slot RAM
// contents are undefined and are only ever used for registered slots.
// A stall on the output only holds the walk when a new event is due.
//
// The controller accepts items only while idle. It sequences the heartbeat
// read-modify-write and the tick walk; the datapath owns the slot RAM (one
// word per slot: reload timeout, countdown and retries left), the valid
// bits kept in flip-flops, the two default registers and the output
// register. During a walk the RAM reads one slot ahead of the slot being
// written back, so each slot retires while the next one is read.
//
module multi_channel_heartbeat_watchdog import mchw_pkg::*; #(
  parameter int unsigned SLOTS        = 16,
  parameter int unsigned COUNTER_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,

  input  logic                cfg_we_i,
  input  logic                cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,

  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_item_t            in_data_i,

  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_item_t           out_data_o
);

  cmd_t    cmd;
  status_t status;

  // Controller: item acceptance and the walk sequence.
  mchw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_mode_i  (in_data_i.mode),
    .status_i   (status),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o)
  );

  // Datapath: slot table, countdown arithmetic and event output.
  mchw_dp #(
    .SLOTS        (SLOTS),
    .COUNTER_BITS (COUNTER_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule
